FILE: src/wsnc_pkg.sv
package wsnc_pkg;

   localparam int MAX_ROWS   = 128;
   localparam int MAX_COLS   = 128;
   localparam int MAX_RADIUS = 7;
   localparam int WSIDE      = 2 * MAX_RADIUS + 1;

   localparam int CELL_DEPTH = MAX_ROWS * MAX_COLS;
   localparam int WGT_DEPTH  = WSIDE * WSIDE;
   localparam int CELL_AW    = (CELL_DEPTH > 1) ? $clog2(CELL_DEPTH) : 1;
   localparam int WGT_AW     = (WGT_DEPTH > 1) ? $clog2(WGT_DEPTH) : 1;
   localparam int WOFF_W     = (WSIDE > 1) ? $clog2(WSIDE) : 1;

   localparam int TYPE_W     = 2;
   localparam int ROW_W      = 7;
   localparam int COL_W      = 7;
   localparam int DIM_W      = 8;
   localparam int RAD_W      = 3;
   localparam int VAL_W      = 16;
   localparam int SUM_W      = 24;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;

   // request codes
   localparam logic [TYPE_W-1:0] REQ_CELL_WR = 2'd0;
   localparam logic [TYPE_W-1:0] REQ_WGT_WR  = 2'd1;
   localparam logic [TYPE_W-1:0] REQ_QUERY   = 2'd2;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_GRID_ROWS = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_GRID_COLS = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_RADIUS    = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_TARGET    = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_TOLERANCE = 3'd4;

   typedef enum logic [2:0] {
      W_IDLE,
      W_SETUP,
      W_SCAN,
      W_DRAIN,
      W_HOLD
   } walk_state_type;

   typedef struct packed {
      logic [DIM_W-1:0]        nr;
      logic [DIM_W-1:0]        nc;
      logic [RAD_W-1:0]        radius;
      logic signed [VAL_W-1:0] target;
      logic [VAL_W-1:0]        tol;
   } cfg_type;

   typedef struct packed {
      logic go;
      logic err;
   } start_type;

   typedef struct packed {
      logic [ROW_W-1:0] row;
      logic [COL_W-1:0] col;
   } qry_type;

   typedef struct packed {
      logic idle;
      logic done;
   } walk_stat_type;

   function automatic logic [CELL_AW-1:0] cell_addr(input logic [ROW_W-1:0] row,
                                                    input logic [COL_W-1:0] col);
      cell_addr = CELL_AW'(int'(row) * MAX_COLS + int'(col));
   endfunction

   function automatic logic [WGT_AW-1:0] wgt_addr(input logic [WOFF_W-1:0] wrow,
                                                  input logic [WOFF_W-1:0] wcol);
      wgt_addr = WGT_AW'(int'(wrow) * WSIDE + int'(wcol));
   endfunction

endpackage

FILE: src/wsnc_if.sv
interface wsnc_req_if;
   logic                                 valid;
   logic                                 ready;
   logic [wsnc_pkg::TYPE_W-1:0]          req_type;
   logic [wsnc_pkg::ROW_W-1:0]           row;
   logic [wsnc_pkg::COL_W-1:0]           col;
   logic signed [wsnc_pkg::VAL_W-1:0]    value;

   modport source (output valid, req_type, row, col, value, input ready);
   modport sink   (input valid, req_type, row, col, value, output ready);
endinterface

interface wsnc_rsp_if;
   logic                                 valid;
   logic                                 ready;
   logic signed [wsnc_pkg::SUM_W-1:0]    weighted_count;
   logic [wsnc_pkg::ROW_W-1:0]           out_row;
   logic [wsnc_pkg::COL_W-1:0]           out_col;
   logic                                 query_error;

   modport source (output valid, weighted_count, out_row, out_col, query_error,
                   input ready);
   modport sink   (input valid, weighted_count, out_row, out_col, query_error,
                   output ready);
endinterface

interface wsnc_csr_if;
   logic                                 valid;
   logic                                 ready;
   logic [wsnc_pkg::CSR_IDX_W-1:0]       index;
   logic [wsnc_pkg::CSR_DATA_W-1:0]      data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

FILE: src/wsnc_ram.sv
module wsnc_ram #(
   parameter int DEPTH = 16,
   parameter int WIDTH = 16,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    waddr,
   input  logic [WIDTH-1:0] wdata,
   input  logic [AW-1:0]    raddr,
   output logic [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

FILE: src/wsnc_walk.sv
module wsnc_walk (
   input  logic                                clock,
   input  logic                                reset,
   input  wsnc_pkg::start_type                 start,
   input  wsnc_pkg::qry_type                   qry,
   input  wsnc_pkg::cfg_type                   cfg,
   input  logic                                take,
   output wsnc_pkg::walk_stat_type             stat,
   output logic signed [wsnc_pkg::SUM_W-1:0]   sum,
   output logic [wsnc_pkg::CELL_AW-1:0]        cell_raddr,
   input  logic [wsnc_pkg::VAL_W-1:0]          cell_rdata,
   output logic [wsnc_pkg::WGT_AW-1:0]         wgt_raddr,
   input  logic [wsnc_pkg::VAL_W-1:0]          wgt_rdata
);

   wsnc_pkg::walk_state_type state_ff, state_in;

   logic [wsnc_pkg::ROW_W-1:0]  rr_ff, rr_in, r_hi_ff, r_hi_in;
   logic [wsnc_pkg::COL_W-1:0]  cc_ff, cc_in, c_lo_ff, c_lo_in, c_hi_ff, c_hi_in;
   logic [wsnc_pkg::WOFF_W-1:0] wr_ff, wr_in, wc_ff, wc_in, wc0_ff, wc0_in;

   logic                        rd_vld_ff, rd_vld_in;
   logic                        mt_vld_ff, mt_vld_in;
   logic                        match_ff, match_in;
   logic signed [wsnc_pkg::VAL_W-1:0] wgt_ff;
   logic signed [wsnc_pkg::SUM_W-1:0] acc_ff, acc_in;

   logic                        last;

   // window bounds
   logic [wsnc_pkg::DIM_W-1:0]  d_w, row_w, col_w;
   logic [wsnc_pkg::DIM_W-1:0]  r_lo_w, r_top_w, r_hi_w, wr0_w;
   logic [wsnc_pkg::DIM_W-1:0]  c_lo_w, c_top_w, c_hi_w, wc0_w;

   // match test
   logic signed [wsnc_pkg::VAL_W:0] diff;
   logic [wsnc_pkg::VAL_W:0]        mag;

   always_comb begin
      d_w     = wsnc_pkg::DIM_W'(cfg.radius);
      row_w   = wsnc_pkg::DIM_W'(qry.row);
      col_w   = wsnc_pkg::DIM_W'(qry.col);
      r_lo_w  = (row_w >= d_w) ? row_w - d_w : '0;
      c_lo_w  = (col_w >= d_w) ? col_w - d_w : '0;
      r_top_w = row_w + d_w;
      c_top_w = col_w + d_w;
      // stop at the last row and column of the grid
      r_hi_w  = (r_top_w > cfg.nr - wsnc_pkg::DIM_W'(1)) ?
                cfg.nr - wsnc_pkg::DIM_W'(1) : r_top_w;
      c_hi_w  = (c_top_w > cfg.nc - wsnc_pkg::DIM_W'(1)) ?
                cfg.nc - wsnc_pkg::DIM_W'(1) : c_top_w;
      wr0_w   = r_lo_w + d_w - row_w;
      wc0_w   = c_lo_w + d_w - col_w;
   end

   assign last = (rr_ff == r_hi_ff) && (cc_ff == c_hi_ff);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         wsnc_pkg::W_IDLE: begin
            if (start.go) begin
               state_in = start.err ? wsnc_pkg::W_HOLD : wsnc_pkg::W_SETUP;
            end
         end
         wsnc_pkg::W_SETUP: state_in = wsnc_pkg::W_SCAN;
         wsnc_pkg::W_SCAN: begin
            if (last) begin
               state_in = wsnc_pkg::W_DRAIN;
            end
         end
         wsnc_pkg::W_DRAIN: begin
            if (!rd_vld_ff && !mt_vld_ff) begin
               state_in = wsnc_pkg::W_HOLD;
            end
         end
         wsnc_pkg::W_HOLD: begin
            if (take) begin
               state_in = wsnc_pkg::W_IDLE;
            end
         end
         default: state_in = wsnc_pkg::W_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      stat.idle = 1'b0;
      stat.done = 1'b0;
      rd_vld_in = 1'b0;
      case (state_ff)
         wsnc_pkg::W_IDLE: stat.idle = 1'b1;
         wsnc_pkg::W_SCAN: rd_vld_in = 1'b1;
         wsnc_pkg::W_HOLD: stat.done = 1'b1;
         default: ;
      endcase
   end

   // window counters
   always_comb begin
      rr_in   = rr_ff;
      cc_in   = cc_ff;
      wr_in   = wr_ff;
      wc_in   = wc_ff;
      wc0_in  = wc0_ff;
      r_hi_in = r_hi_ff;
      c_lo_in = c_lo_ff;
      c_hi_in = c_hi_ff;
      if (state_ff == wsnc_pkg::W_SETUP) begin
         rr_in   = r_lo_w[wsnc_pkg::ROW_W-1:0];
         cc_in   = c_lo_w[wsnc_pkg::COL_W-1:0];
         wr_in   = wr0_w[wsnc_pkg::WOFF_W-1:0];
         wc_in   = wc0_w[wsnc_pkg::WOFF_W-1:0];
         wc0_in  = wc0_w[wsnc_pkg::WOFF_W-1:0];
         r_hi_in = r_hi_w[wsnc_pkg::ROW_W-1:0];
         c_lo_in = c_lo_w[wsnc_pkg::COL_W-1:0];
         c_hi_in = c_hi_w[wsnc_pkg::COL_W-1:0];
      end else if (state_ff == wsnc_pkg::W_SCAN) begin
         if (cc_ff == c_hi_ff) begin
            cc_in = c_lo_ff;
            wc_in = wc0_ff;
            rr_in = rr_ff + wsnc_pkg::ROW_W'(1);
            wr_in = wr_ff + wsnc_pkg::WOFF_W'(1);
         end else begin
            cc_in = cc_ff + wsnc_pkg::COL_W'(1);
            wc_in = wc_ff + wsnc_pkg::WOFF_W'(1);
         end
      end
   end

   assign cell_raddr = wsnc_pkg::cell_addr(rr_ff, cc_ff);
   assign wgt_raddr  = wsnc_pkg::wgt_addr(wr_ff, wc_ff);

   always_comb begin
      diff      = $signed({cell_rdata[wsnc_pkg::VAL_W-1], cell_rdata}) -
                  $signed({cfg.target[wsnc_pkg::VAL_W-1], cfg.target});
      mag       = diff[wsnc_pkg::VAL_W] ? $unsigned(-diff) : $unsigned(diff);
      match_in  = mag < {1'b0, cfg.tol};
      mt_vld_in = rd_vld_ff;
   end

   always_comb begin
      acc_in = acc_ff;
      if (state_ff == wsnc_pkg::W_IDLE && start.go) begin
         acc_in = '0;
      end else if (mt_vld_ff && match_ff) begin
         acc_in = acc_ff + wsnc_pkg::SUM_W'(wgt_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= wsnc_pkg::W_IDLE;
         rd_vld_ff <= 1'b0;
         mt_vld_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         rd_vld_ff <= rd_vld_in;
         mt_vld_ff <= mt_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      rr_ff    <= rr_in;
      cc_ff    <= cc_in;
      wr_ff    <= wr_in;
      wc_ff    <= wc_in;
      wc0_ff   <= wc0_in;
      r_hi_ff  <= r_hi_in;
      c_lo_ff  <= c_lo_in;
      c_hi_ff  <= c_hi_in;
      match_ff <= match_in;
      wgt_ff   <= $signed(wgt_rdata);
      acc_ff   <= acc_in;
   end

   assign sum = acc_ff;

endmodule

FILE: src/weighted_state_neighbourhood_count.sv
// Writes of a cell or a weight do not stall; the next transaction is accepted right after.
// A query inside the grid reads, in the scan state, the N window cells left after clipping
// (1 to 225), one cell read per cycle, then drains and waits in hold for the result register;
// a query outside the grid goes straight to hold. One query is in flight at a time: the next
// transaction is taken the cycle after the result register loads, later while a result waits.
// Reset restores the register defaults and empties the control path; memories are not cleared.
module weighted_state_neighbourhood_count (
   input logic      clock,
   input logic      reset,
   wsnc_req_if.sink   req,
   wsnc_rsp_if.source rsp,
   wsnc_csr_if.sink   csr
);

   logic [wsnc_pkg::DIM_W-1:0]        grid_rows_ff, grid_cols_ff;
   logic [wsnc_pkg::RAD_W-1:0]        radius_ff;
   logic signed [wsnc_pkg::VAL_W-1:0] target_ff;
   logic [wsnc_pkg::VAL_W-1:0]        tol_ff;

   wsnc_pkg::cfg_type       cfg;
   wsnc_pkg::start_type     start;
   wsnc_pkg::qry_type       qry_ff, qry_in;
   wsnc_pkg::walk_stat_type stat;

   logic                    q_err_ff, q_err_in;
   logic                    req_acc, take;
   logic signed [wsnc_pkg::SUM_W-1:0] sum;

   logic                    rsp_vld_ff, rsp_vld_in;
   logic signed [wsnc_pkg::SUM_W-1:0] rsp_cnt_ff, rsp_cnt_in;
   logic [wsnc_pkg::ROW_W-1:0] rsp_row_ff, rsp_row_in;
   logic [wsnc_pkg::COL_W-1:0] rsp_col_ff, rsp_col_in;
   logic                    rsp_err_ff, rsp_err_in;

   logic                          cell_we, wgt_we;
   logic [wsnc_pkg::CELL_AW-1:0]  cell_raddr;
   logic [wsnc_pkg::WGT_AW-1:0]   wgt_raddr;
   logic [wsnc_pkg::VAL_W-1:0]    cell_rdata, wgt_rdata;

   // configuration registers
   assign csr.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         grid_rows_ff <= wsnc_pkg::DIM_W'(128);
         grid_cols_ff <= wsnc_pkg::DIM_W'(128);
         radius_ff    <= wsnc_pkg::RAD_W'(1);
         target_ff    <= wsnc_pkg::VAL_W'(256);
         tol_ff       <= wsnc_pkg::VAL_W'(128);
      end else if (csr.valid && csr.ready) begin
         case (csr.index)
            wsnc_pkg::CSR_GRID_ROWS: grid_rows_ff <= csr.data[wsnc_pkg::DIM_W-1:0];
            wsnc_pkg::CSR_GRID_COLS: grid_cols_ff <= csr.data[wsnc_pkg::DIM_W-1:0];
            wsnc_pkg::CSR_RADIUS:    radius_ff    <= csr.data[wsnc_pkg::RAD_W-1:0];
            wsnc_pkg::CSR_TARGET:    target_ff    <= $signed(csr.data[wsnc_pkg::VAL_W-1:0]);
            wsnc_pkg::CSR_TOLERANCE: tol_ff       <= csr.data[wsnc_pkg::VAL_W-1:0];
            default: ;
         endcase
      end
   end

   // clamp sizes to the store
   always_comb begin
      cfg.nr     = (int'(grid_rows_ff) > wsnc_pkg::MAX_ROWS) ?
                   wsnc_pkg::DIM_W'(wsnc_pkg::MAX_ROWS) : grid_rows_ff;
      cfg.nc     = (int'(grid_cols_ff) > wsnc_pkg::MAX_COLS) ?
                   wsnc_pkg::DIM_W'(wsnc_pkg::MAX_COLS) : grid_cols_ff;
      cfg.radius = (int'(radius_ff) > wsnc_pkg::MAX_RADIUS) ?
                   wsnc_pkg::RAD_W'(wsnc_pkg::MAX_RADIUS) : radius_ff;
      cfg.target = target_ff;
      cfg.tol    = tol_ff;
   end

   // request side
   assign req.ready = stat.idle;
   assign req_acc   = req.valid && req.ready;

   always_comb begin
      start.go  = req_acc && (req.req_type == wsnc_pkg::REQ_QUERY);
      start.err = ({1'b0, req.row} >= cfg.nr) || ({1'b0, req.col} >= cfg.nc);
      qry_in    = qry_ff;
      q_err_in  = q_err_ff;
      if (start.go) begin
         qry_in.row = req.row;
         qry_in.col = req.col;
         q_err_in   = start.err;
      end
      cell_we = req_acc && (req.req_type == wsnc_pkg::REQ_CELL_WR) &&
                (int'(req.row) < wsnc_pkg::MAX_ROWS) && (int'(req.col) < wsnc_pkg::MAX_COLS);
      wgt_we  = req_acc && (req.req_type == wsnc_pkg::REQ_WGT_WR) &&
                (int'(req.row) < wsnc_pkg::WSIDE) && (int'(req.col) < wsnc_pkg::WSIDE);
   end

   always_ff @(posedge clock) begin
      qry_ff   <= qry_in;
      q_err_ff <= q_err_in;
   end

   wsnc_ram #(
      .DEPTH (wsnc_pkg::CELL_DEPTH),
      .WIDTH (wsnc_pkg::VAL_W)
   ) u_cell_ram (
      .clock (clock),
      .we    (cell_we),
      .waddr (wsnc_pkg::cell_addr(req.row, req.col)),
      .wdata (req.value),
      .raddr (cell_raddr),
      .rdata (cell_rdata)
   );

   wsnc_ram #(
      .DEPTH (wsnc_pkg::WGT_DEPTH),
      .WIDTH (wsnc_pkg::VAL_W)
   ) u_wgt_ram (
      .clock (clock),
      .we    (wgt_we),
      .waddr (wsnc_pkg::wgt_addr(req.row[wsnc_pkg::WOFF_W-1:0],
                                 req.col[wsnc_pkg::WOFF_W-1:0])),
      .wdata (req.value),
      .raddr (wgt_raddr),
      .rdata (wgt_rdata)
   );

   wsnc_walk u_walk (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .qry        (qry_ff),
      .cfg        (cfg),
      .take       (take),
      .stat       (stat),
      .sum        (sum),
      .cell_raddr (cell_raddr),
      .cell_rdata (cell_rdata),
      .wgt_raddr  (wgt_raddr),
      .wgt_rdata  (wgt_rdata)
   );

   // result register: load when empty or being drained this cycle
   assign take = stat.done && (!rsp_vld_ff || rsp.ready);

   always_comb begin
      rsp_vld_in = rsp_vld_ff;
      rsp_cnt_in = rsp_cnt_ff;
      rsp_row_in = rsp_row_ff;
      rsp_col_in = rsp_col_ff;
      rsp_err_in = rsp_err_ff;
      if (rsp_vld_ff && rsp.ready) begin
         rsp_vld_in = 1'b0;
      end
      if (take) begin
         rsp_vld_in = 1'b1;
         rsp_cnt_in = sum;
         rsp_row_in = qry_ff.row;
         rsp_col_in = qry_ff.col;
         rsp_err_in = q_err_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_vld_ff <= 1'b0;
      end else begin
         rsp_vld_ff <= rsp_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_cnt_ff <= rsp_cnt_in;
      rsp_row_ff <= rsp_row_in;
      rsp_col_ff <= rsp_col_in;
      rsp_err_ff <= rsp_err_in;
   end

   assign rsp.valid          = rsp_vld_ff;
   assign rsp.weighted_count = rsp_cnt_ff;
   assign rsp.out_row        = rsp_row_ff;
   assign rsp.out_col        = rsp_col_ff;
   assign rsp.query_error    = rsp_err_ff;

endmodule

FILE: sim/testbench.sv
`timescale 1ns / 100ps

module testbench;
   import wsnc_pkg::*;

   localparam logic [TYPE_W-1:0]    REQ_SPARE = 2'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE = 3'd7;
   localparam int                   ITEM_TARGET = 600;

   typedef struct packed {
      logic signed [SUM_W-1:0] count;
      logic [ROW_W-1:0]        row;
      logic [COL_W-1:0]        col;
      logic                    err;
   } count_result_type;

   typedef struct packed {
      logic                    is_csr;
      logic [CSR_IDX_W-1:0]    csr_idx;
      logic [CSR_DATA_W-1:0]   csr_data;
      logic [TYPE_W-1:0]       kind;
      logic [ROW_W-1:0]        row;
      logic [COL_W-1:0]        col;
      logic [VAL_W-1:0]        value;
      logic                    typed;
      logic signed [SUM_W-1:0] tcount;
      logic                    terr;
   } plan_step_type;

   logic clock;
   logic reset;

   wsnc_req_if req_bus ();
   wsnc_rsp_if rsp_bus ();
   wsnc_csr_if csr_bus ();

   weighted_state_neighbourhood_count dut (
      .clock (clock),
      .reset (reset),
      .req   (req_bus),
      .rsp   (rsp_bus),
      .csr   (csr_bus)
   );

   // local copy of the block's registers and memories
   logic [DIM_W-1:0]        cfg_rows;
   logic [DIM_W-1:0]        cfg_cols;
   logic [RAD_W-1:0]        cfg_radius;
   logic signed [VAL_W-1:0] cfg_target;
   logic [VAL_W-1:0]        cfg_tol;

   logic signed [VAL_W-1:0] cell_mem [CELL_DEPTH];
   bit                      cell_seen [CELL_DEPTH];
   logic signed [VAL_W-1:0] weight_mem [WGT_DEPTH];
   bit                      weight_seen [WGT_DEPTH];

   count_result_type pending_counts [$];
   count_result_type want;
   plan_step_type    plan [$];
   int            mismatch_count;
   int            idle_pct;
   int            stall_pct;
   int            sent_count;

   always #5 clock = ~clock;

   initial begin
      #50ms;
      $display("Regression FAIL");
      $finish;
   end

   function automatic int grid_span(input logic [DIM_W-1:0] size);
      return (int'(size) < MAX_ROWS) ? int'(size) : MAX_ROWS;
   endfunction

   function automatic logic signed [SUM_W-1:0] predict_count(input int r, input int c);
      int nr, nc, d, di, dj, rr, cc, diff, acc;
      nr  = grid_span(cfg_rows);
      nc  = grid_span(cfg_cols);
      d   = (int'(cfg_radius) < MAX_RADIUS) ? int'(cfg_radius) : MAX_RADIUS;
      acc = 0;
      for (di = -d; di <= d; di++) begin
         rr = r + di;
         if (rr >= 0 && rr < nr) begin
            for (dj = -d; dj <= d; dj++) begin
               cc = c + dj;
               if (cc >= 0 && cc < nc) begin
                  diff = int'(cell_mem[rr * MAX_COLS + cc]) - int'(cfg_target);
                  if (diff < 0) diff = -diff;
                  if (diff < int'(cfg_tol))
                     acc += int'(weight_mem[(di + d) * WSIDE + (dj + d)]);
               end
            end
         end
      end
      return acc[SUM_W-1:0];
   endfunction

   // bias cell values toward the match band, including its exact edge
   function automatic logic [VAL_W-1:0] cell_value();
      int pick, off;
      pick = $urandom_range(19);
      if (pick >= 13) return VAL_W'($urandom);
      if (pick < 3)
         off = int'(cfg_tol);
      else if (pick < 6)
         off = (cfg_tol != 0) ? int'(cfg_tol) - 1 : 0;
      else
         off = int'($urandom_range(int'(cfg_tol)));
      return VAL_W'(int'(cfg_target) + ($urandom_range(1) ? off : -off));
   endfunction

   function automatic int pick_coord(input int n);
      int band;
      if (n == 0 || $urandom_range(99) < 5) return $urandom_range(MAX_ROWS - 1);
      band = (n < 12) ? n : 12;
      if ($urandom_range(1)) return $urandom_range(band - 1);
      return $urandom_range(n - 1, n - band);
   endfunction

   function automatic plan_step_type cfg_step(input logic [CSR_IDX_W-1:0] idx,
                                              input logic [CSR_DATA_W-1:0] data);
      plan_step_type s;
      s          = '0;
      s.is_csr   = 1'b1;
      s.csr_idx  = idx;
      s.csr_data = data;
      return s;
   endfunction

   function automatic plan_step_type req_step(input logic [TYPE_W-1:0] kind, input int row,
                                              input int col, input logic [VAL_W-1:0] value);
      plan_step_type s;
      s       = '0;
      s.kind  = kind;
      s.row   = ROW_W'(row);
      s.col   = COL_W'(col);
      s.value = value;
      return s;
   endfunction

   function automatic plan_step_type check_step(input int row, input int col,
                                                input logic signed [SUM_W-1:0] count,
                                                input logic err);
      plan_step_type s;
      s        = req_step(REQ_QUERY, row, col, '0);
      s.typed  = 1'b1;
      s.tcount = count;
      s.terr   = err;
      return s;
   endfunction

   task automatic push_req(input logic [TYPE_W-1:0] kind, input logic [ROW_W-1:0] row,
                           input logic [COL_W-1:0] col, input logic [VAL_W-1:0] value,
                           input bit typed, input logic signed [SUM_W-1:0] tcount,
                           input bit terr);
      count_result_type exp_item;
      while ($urandom_range(99) < idle_pct) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid    <= 1'b1;
      req_bus.req_type <= kind;
      req_bus.row      <= row;
      req_bus.col      <= col;
      req_bus.value    <= value;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      sent_count++;
      // transaction accepted: advance the local copy
      case (kind)
         REQ_CELL_WR: begin
            cell_mem[int'(row) * MAX_COLS + int'(col)]  = value;
            cell_seen[int'(row) * MAX_COLS + int'(col)] = 1'b1;
         end
         REQ_WGT_WR: begin
            if (int'(row) < WSIDE && int'(col) < WSIDE) begin
               weight_mem[int'(row) * WSIDE + int'(col)]  = value;
               weight_seen[int'(row) * WSIDE + int'(col)] = 1'b1;
            end
         end
         REQ_QUERY: begin
            exp_item.row = row;
            exp_item.col = col;
            if (typed) begin
               exp_item.count = tcount;
               exp_item.err   = terr;
            end else if (int'(row) < grid_span(cfg_rows) && int'(col) < grid_span(cfg_cols))
               begin
               exp_item.count = predict_count(int'(row), int'(col));
               exp_item.err   = 1'b0;
            end else begin
               exp_item.count = '0;
               exp_item.err   = 1'b1;
            end
            pending_counts.push_back(exp_item);
         end
         default: ;
      endcase
   endtask

   // load every cell and weight the query window will read that was never written
   task automatic prime_window(input int r, input int c);
      int nr, nc, d, di, dj, rr, cc;
      nr = grid_span(cfg_rows);
      nc = grid_span(cfg_cols);
      if (r >= nr || c >= nc) return;
      d = int'(cfg_radius);
      for (di = -d; di <= d; di++) begin
         for (dj = -d; dj <= d; dj++) begin
            rr = r + di;
            cc = c + dj;
            if (rr >= 0 && rr < nr && cc >= 0 && cc < nc) begin
               if (!cell_seen[rr * MAX_COLS + cc])
                  push_req(REQ_CELL_WR, ROW_W'(rr), COL_W'(cc), cell_value(), 0, '0, 0);
               if (!weight_seen[(di + d) * WSIDE + (dj + d)])
                  push_req(REQ_WGT_WR, ROW_W'(di + d), COL_W'(dj + d), VAL_W'($urandom),
                           0, '0, 0);
            end
         end
      end
   endtask

   // drop valid, drain outstanding queries, leave room for a trailing write
   task automatic settle();
      req_bus.valid <= 1'b0;
      while (pending_counts.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] data);
      settle();
      csr_bus.valid <= 1'b1;
      csr_bus.index <= idx;
      csr_bus.data  <= data;
      @(posedge clock);
      while (!csr_bus.ready) @(posedge clock);
      case (idx)
         CSR_GRID_ROWS: cfg_rows   = data[DIM_W-1:0];
         CSR_GRID_COLS: cfg_cols   = data[DIM_W-1:0];
         CSR_RADIUS:    cfg_radius = data[RAD_W-1:0];
         CSR_TARGET:    cfg_target = data;
         CSR_TOLERANCE: cfg_tol    = data;
         default: ;
      endcase
      csr_bus.valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic apply_settings(input int k);
      logic [DIM_W-1:0] rows, cols;
      logic [VAL_W-1:0] target, tol;
      rows = DIM_W'($urandom_range(3, 40));
      cols = DIM_W'($urandom_range(3, 40));
      case ($urandom_range(9))
         0: rows = 8'd0;
         1: rows = DIM_W'($urandom_range(129, 255));
         2: cols = DIM_W'($urandom_range(129, 255));
         3: cols = 8'd2;
         default: ;
      endcase
      if (k == 0) begin
         rows = 8'd1;
         cols = 8'd1;
      end else if (k == 7) begin
         rows = 8'd128;
         cols = 8'd128;
      end
      case ($urandom_range(5))
         0: target = 16'h8000;
         1: target = 16'h7FFF;
         default: target = VAL_W'($urandom);
      endcase
      case ($urandom_range(5))
         0: tol = 16'h0000;
         1: tol = 16'hFFFF;
         default: tol = VAL_W'($urandom_range(1, 2048));
      endcase
      // upper data bits are don't-care for the narrow registers
      write_csr(CSR_GRID_ROWS, {8'($urandom), rows});
      write_csr(CSR_GRID_COLS, {8'($urandom), cols});
      write_csr(CSR_RADIUS, (k == 0 || k == 7) ? 16'd7 : CSR_DATA_W'($urandom_range(7)));
      write_csr(CSR_TARGET, target);
      write_csr(CSR_TOLERANCE, tol);
      if (k == 3) write_csr(CSR_SPARE, CSR_DATA_W'($urandom));
   endtask

   // send transactions until count more have been accepted, window loads included
   task automatic run_items(input int count);
      int stop, roll, r, c;
      stop = sent_count + count;
      while (sent_count < stop) begin
         roll = $urandom_range(99);
         r    = pick_coord(grid_span(cfg_rows));
         c    = pick_coord(grid_span(cfg_cols));
         if (roll < 45) begin
            prime_window(r, c);
            push_req(REQ_QUERY, ROW_W'(r), COL_W'(c), VAL_W'($urandom), 0, '0, 0);
         end else if (roll < 82) begin
            push_req(REQ_CELL_WR, ROW_W'(r), COL_W'(c), cell_value(), 0, '0, 0);
         end else if (roll < 94) begin
            push_req(REQ_WGT_WR, ROW_W'($urandom_range(WSIDE - 1)),
                     COL_W'($urandom_range(WSIDE - 1)), VAL_W'($urandom), 0, '0, 0);
         end else if (roll < 97) begin
            push_req(REQ_SPARE, ROW_W'($urandom), COL_W'($urandom), VAL_W'($urandom),
                     0, '0, 0);
         end else begin
            push_req(REQ_WGT_WR, ROW_W'($urandom_range(127, WSIDE)), COL_W'($urandom),
                     VAL_W'($urandom), 0, '0, 0);
         end
      end
   endtask

   // result side: random backpressure and in-order compare
   always @(posedge clock) begin
      rsp_bus.ready <= ($urandom_range(99) >= stall_pct);
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (pending_counts.size() == 0) begin
            $error("result with none pending: row %0d col %0d count %0d",
                   rsp_bus.out_row, rsp_bus.out_col, rsp_bus.weighted_count);
            mismatch_count++;
         end else begin
            want = pending_counts.pop_front();
            if (rsp_bus.weighted_count !== want.count) begin
               $error("weighted_count expected %0d actual %0d", want.count,
                      rsp_bus.weighted_count);
               mismatch_count++;
            end
            if (rsp_bus.out_row !== want.row) begin
               $error("out_row expected %0d actual %0d", want.row, rsp_bus.out_row);
               mismatch_count++;
            end
            if (rsp_bus.out_col !== want.col) begin
               $error("out_col expected %0d actual %0d", want.col, rsp_bus.out_col);
               mismatch_count++;
            end
            if (rsp_bus.query_error !== want.err) begin
               $error("query_error expected %0d actual %0d", want.err,
                      rsp_bus.query_error);
               mismatch_count++;
            end
         end
      end
   end

   initial begin
      int phase, half, i, budget;
      clock            = 1'b0;
      reset            = 1'b1;
      req_bus.valid    = 1'b0;
      req_bus.req_type = REQ_CELL_WR;
      req_bus.row      = '0;
      req_bus.col      = '0;
      req_bus.value    = '0;
      rsp_bus.ready    = 1'b0;
      csr_bus.valid    = 1'b0;
      csr_bus.index    = CSR_GRID_ROWS;
      csr_bus.data     = '0;
      mismatch_count   = 0;
      idle_pct         = 0;
      stall_pct        = 0;
      sent_count       = 0;
      cfg_rows         = 8'd128;
      cfg_cols         = 8'd128;
      cfg_radius       = 3'd1;
      cfg_target       = 16'sd256;
      cfg_tol          = 16'd128;
      for (i = 0; i < CELL_DEPTH; i++) begin
         cell_mem[i]  = '0;
         cell_seen[i] = 1'b0;
      end
      for (i = 0; i < WGT_DEPTH; i++) begin
         weight_mem[i]  = '0;
         weight_seen[i] = 1'b0;
      end

      // single-cell window: match, edge of tolerance, weight extremes
      plan.push_back(cfg_step(CSR_RADIUS, 16'd0));
      plan.push_back(req_step(REQ_WGT_WR, 0, 0, 16'h7FFF));
      plan.push_back(req_step(REQ_CELL_WR, 5, 5, 16'h0100));
      plan.push_back(check_step(5, 5, 24'sd32767, 1'b0));
      plan.push_back(req_step(REQ_CELL_WR, 5, 5, 16'h0180));
      plan.push_back(check_step(5, 5, 24'sd0, 1'b0));
      plan.push_back(req_step(REQ_CELL_WR, 5, 5, 16'h017F));
      plan.push_back(req_step(REQ_WGT_WR, 0, 0, 16'h8000));
      plan.push_back(check_step(5, 5, -24'sd32768, 1'b0));
      plan.push_back(req_step(REQ_QUERY, 127, 127, 16'hFFFF));
      // clipping at corners and edges, and queries outside the grid
      plan.push_back(cfg_step(CSR_RADIUS, 16'd1));
      plan.push_back(req_step(REQ_QUERY, 0, 0, 16'h0000));
      plan.push_back(cfg_step(CSR_GRID_ROWS, 16'd4));
      plan.push_back(check_step(4, 0, 24'sd0, 1'b1));
      plan.push_back(req_step(REQ_QUERY, 3, 127, 16'h5A5A));
      plan.push_back(check_step(127, 127, 24'sd0, 1'b1));
      plan.push_back(cfg_step(CSR_GRID_COLS, 16'd0));
      plan.push_back(check_step(0, 0, 24'sd0, 1'b1));
      // oversized sizes clamp to the store; full window against the last row and column
      plan.push_back(cfg_step(CSR_GRID_ROWS, 16'hFFC8));
      plan.push_back(cfg_step(CSR_GRID_COLS, 16'h00FF));
      plan.push_back(cfg_step(CSR_RADIUS, 16'd7));
      plan.push_back(req_step(REQ_QUERY, 127, 127, 16'h0000));
      plan.push_back(req_step(REQ_QUERY, 0, 0, 16'h0000));
      plan.push_back(req_step(REQ_QUERY, 64, 127, 16'h0000));
      // dropped transactions
      plan.push_back(req_step(REQ_WGT_WR, 15, 3, 16'h1234));
      plan.push_back(req_step(REQ_WGT_WR, 3, 127, 16'h4321));
      plan.push_back(req_step(REQ_WGT_WR, 127, 127, 16'hFFFF));
      plan.push_back(req_step(REQ_SPARE, 2, 2, 16'h0100));
      // cells written outside the active grid are kept
      plan.push_back(cfg_step(CSR_GRID_ROWS, 16'd8));
      plan.push_back(cfg_step(CSR_GRID_COLS, 16'd8));
      plan.push_back(req_step(REQ_CELL_WR, 20, 20, 16'h0100));
      plan.push_back(check_step(20, 20, 24'sd0, 1'b1));
      plan.push_back(cfg_step(CSR_GRID_ROWS, 16'd128));
      plan.push_back(cfg_step(CSR_GRID_COLS, 16'd128));
      plan.push_back(cfg_step(CSR_RADIUS, 16'd0));
      plan.push_back(req_step(REQ_QUERY, 20, 20, 16'h0000));
      // target and tolerance extremes
      plan.push_back(cfg_step(CSR_TARGET, 16'h8000));
      plan.push_back(cfg_step(CSR_TOLERANCE, 16'hFFFF));
      plan.push_back(req_step(REQ_QUERY, 20, 20, 16'h0000));
      plan.push_back(cfg_step(CSR_TARGET, 16'h7FFF));
      plan.push_back(cfg_step(CSR_TOLERANCE, 16'h0000));
      plan.push_back(check_step(20, 20, 24'sd0, 1'b0));

      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (plan[i]) begin
         if (plan[i].is_csr)
            write_csr(plan[i].csr_idx, plan[i].csr_data);
         else begin
            if (plan[i].kind == REQ_QUERY) prime_window(int'(plan[i].row), int'(plan[i].col));
            push_req(plan[i].kind, plan[i].row, plan[i].col, plan[i].value,
                     plan[i].typed, plan[i].tcount, plan[i].terr);
         end
      end

      for (phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin idle_pct = 0;  stall_pct = 0;  end
            1: begin idle_pct = 76; stall_pct = 0;  end
            2: begin idle_pct = 0;  stall_pct = 76; end
            default: begin idle_pct = 38; stall_pct = 38; end
         endcase
         for (half = 0; half < 2; half++) begin
            apply_settings(phase * 2 + half);
            // spread what is left of the item budget over the remaining settings
            budget = (ITEM_TARGET - sent_count) / (8 - (phase * 2 + half));
            run_items((budget > 30) ? budget : 30);
         end
      end

      settle();
      // hold long enough for a stray result from a full window to show up
      repeat (240) @(posedge clock);
      if (mismatch_count == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule
